>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the scaler's port checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// next-cycle implication, checked through reset as well
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> hw/rtl/nnis_pkg.sv
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared constants, codes and types of the nearest-neighbor scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package nnis_pkg;

   // parameter defaults
   localparam int MAX_SRC_DIM_DEF = 256;
   localparam int MAX_DST_DIM_DEF = 4096;
   localparam int PIXEL_BITS_DEF  = 24;

   // register and field widths
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_SRC_W  = 9;
   localparam int CSR_DST_W  = 13;
   localparam int ROWCOL_W   = 12;

   // decoupling queue depth
   localparam int QUEUE_DEPTH = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SRC_ROWS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_COLS = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DST_ROWS = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DST_COLS = 8'd3;

   // register reset values
   localparam logic [CSR_SRC_W-1:0] RST_SRC_DIM = 9'd256;
   localparam logic [CSR_DST_W-1:0] RST_DST_DIM = 13'd256;

   // opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EMIT = 1'b1;

   // control part of a queue entry
   typedef struct packed {
      logic is_emit;
      logic frame_done;
   } nnis_ctl_type;

   function automatic int addr_width(input int max_src);
      return $clog2(max_src * max_src);
   endfunction

   function automatic int entry_width(input int max_src, input int pixel_bits);
      return $bits(nnis_ctl_type) + 2 * ROWCOL_W + addr_width(max_src) + pixel_bits;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/nnis_channels.sv
// ----------------------------------------------------------------------------
// nnis channels
// Valid/ready channel interfaces: pixel requests, results, register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface nnis_req_if #(
   parameter int PIXEL_BITS = nnis_pkg::PIXEL_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic                  opcode;
   logic [PIXEL_BITS-1:0] pixel_in;

   modport source (output valid, output opcode, output pixel_in, input ready);
   modport sink   (input valid, input opcode, input pixel_in, output ready);
endinterface

interface nnis_rsp_if #(
   parameter int PIXEL_BITS = nnis_pkg::PIXEL_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic [PIXEL_BITS-1:0]         pixel_out;
   logic [nnis_pkg::ROWCOL_W-1:0] out_row;
   logic [nnis_pkg::ROWCOL_W-1:0] out_col;
   logic                          frame_done;

   modport source (output valid, output pixel_out, output out_row, output out_col,
                   output frame_done, input ready);
   modport sink   (input valid, input pixel_out, input out_row, input out_col,
                   input frame_done, output ready);
endinterface

interface nnis_csr_if;
   logic                            valid;
   logic                            ready;
   logic [nnis_pkg::CSR_IDX_W-1:0]  index;
   logic [nnis_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/nnis_div.sv
// ----------------------------------------------------------------------------
// nnis_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nnis_div #(
   parameter int NW = 20,
   parameter int DW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quotient,
   output logic [DW-1:0] remainder
);

   localparam int CNT_W = $clog2(NW + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NW-1:0]    quo_ff, quo_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    dvs_ff, dvs_in;
   logic [DW:0]      rem_sh;
   logic [DW:0]      rem_sub;
   logic             fits;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[NW-1]};
      fits    = rem_sh >= {1'b0, dvs_ff};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NW);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NW-2:0], fits};
         rem_in = fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

>>> hw/rtl/nnis_fifo.sv
// ----------------------------------------------------------------------------
// nnis_fifo
// Small register queue between the front and back halves.
// ----------------------------------------------------------------------------
`default_nettype none

module nnis_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = nnis_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             push_ok;
   logic             pop_ok;

   assign full    = cnt_ff == CW'(DEPTH);
   assign empty   = cnt_ff == '0;
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign rdata   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slots_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/nnis_front.sv
// ----------------------------------------------------------------------------
// nnis_front
// Register file, load counter, destination stepping and index accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module nnis_front #(
   parameter int MAX_SRC_DIM = nnis_pkg::MAX_SRC_DIM_DEF,
   parameter int MAX_DST_DIM = nnis_pkg::MAX_DST_DIM_DEF,
   parameter int PIXEL_BITS  = nnis_pkg::PIXEL_BITS_DEF,
   parameter int ENTRY_W     = nnis_pkg::entry_width(MAX_SRC_DIM, PIXEL_BITS)
) (
   input  logic               clock,
   input  logic               reset,
   nnis_req_if.sink           req,
   nnis_csr_if.sink           csr,
   input  logic               q_full,
   output logic               q_push,
   output logic [ENTRY_W-1:0] q_entry
);

   localparam int AW       = nnis_pkg::addr_width(MAX_SRC_DIM);
   localparam int SRC_BITS = $clog2(MAX_SRC_DIM + 1);
   localparam int SW       = (SRC_BITS > nnis_pkg::CSR_SRC_W) ? SRC_BITS : nnis_pkg::CSR_SRC_W;
   localparam int DST_BITS = $clog2(MAX_DST_DIM + 1);
   localparam int DW       = (DST_BITS > nnis_pkg::CSR_DST_W) ? DST_BITS : nnis_pkg::CSR_DST_W;
   localparam int RW       = $clog2(MAX_DST_DIM);
   localparam int NW       = RW + SW;
   localparam int CW       = (RW + 1 > DW) ? RW + 1 : DW;
   localparam int RCW      = nnis_pkg::ROWCOL_W;

   localparam logic [1:0] S_RUN   = 2'd0;
   localparam logic [1:0] S_START = 2'd1;
   localparam logic [1:0] S_WAIT  = 2'd2;

   localparam logic [1:0] SEL_ROW_STEP = 2'd0;
   localparam logic [1:0] SEL_COL_STEP = 2'd1;
   localparam logic [1:0] SEL_ROW_POS  = 2'd2;
   localparam logic [1:0] SEL_COL_POS  = 2'd3;

   // registers
   logic [nnis_pkg::CSR_SRC_W-1:0] src_rows_ff, src_rows_in;
   logic [nnis_pkg::CSR_SRC_W-1:0] src_cols_ff, src_cols_in;
   logic [nnis_pkg::CSR_DST_W-1:0] dst_rows_ff, dst_rows_in;
   logic [nnis_pkg::CSR_DST_W-1:0] dst_cols_ff, dst_cols_in;

   // sequencer
   logic [1:0] state_ff, state_in;
   logic [1:0] sel_ff, sel_in;
   logic       stale_ff, stale_in;

   // counters and accumulators
   logic [AW-1:0] la_ff, la_in;
   logic [AW:0]   count_ff, count_in;
   logic [RW-1:0] row_ff, row_in;
   logic [RW-1:0] col_ff, col_in;
   logic [NW-1:0] rowq_ff, rowq_in;
   logic [DW-1:0] rowr_ff, rowr_in;
   logic [NW-1:0] colq_ff, colq_in;
   logic [DW-1:0] colr_ff, colr_in;
   logic [SW-1:0] rsq_ff, rsq_in;
   logic [DW-1:0] rsr_ff, rsr_in;
   logic [SW-1:0] csq_ff, csq_in;
   logic [DW-1:0] csr_r_ff, csr_r_in;

   // effective dimensions
   logic [SW-1:0] sr_ext, sc_ext, sr, sc;
   logic [DW-1:0] dr_ext, dc_ext, dr, dc;

   logic          csr_wr;
   logic          take;
   logic          is_emit;
   logic [2*SW-1:0] cnt_wide;
   logic [AW-1:0] la_cur;
   logic [AW:0]   la_nxt;
   logic [SW-1:0] r_idx, c_idx;
   logic [2*SW-1:0] addr_wide;
   logic [AW-1:0] q_addr;
   logic [CW-1:0] col_p1, row_p1;
   logic          col_last, row_last;
   logic [DW:0]   rsum, csum;
   logic          rcarry, ccarry;

   logic          div_start;
   logic [NW-1:0] div_dividend;
   logic [DW-1:0] div_divisor;
   logic          div_done;
   logic [NW-1:0] div_quo;
   logic [DW-1:0] div_rem;

   nnis_pkg::nnis_ctl_type q_ctl;

   nnis_div #(
      .NW (NW),
      .DW (DW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // out-of-range sizes: zero acts as one, too large acts as the maximum
   always_comb begin
      sr_ext = SW'(src_rows_ff);
      sc_ext = SW'(src_cols_ff);
      dr_ext = DW'(dst_rows_ff);
      dc_ext = DW'(dst_cols_ff);
      sr = (sr_ext == '0) ? SW'(1) : ((sr_ext > SW'(MAX_SRC_DIM)) ? SW'(MAX_SRC_DIM) : sr_ext);
      sc = (sc_ext == '0) ? SW'(1) : ((sc_ext > SW'(MAX_SRC_DIM)) ? SW'(MAX_SRC_DIM) : sc_ext);
      dr = (dr_ext == '0) ? DW'(1) : ((dr_ext > DW'(MAX_DST_DIM)) ? DW'(MAX_DST_DIM) : dr_ext);
      dc = (dc_ext == '0) ? DW'(1) : ((dc_ext > DW'(MAX_DST_DIM)) ? DW'(MAX_DST_DIM) : dc_ext);
   end

   assign csr.ready = 1'b1;
   assign csr_wr    = csr.valid;
   assign req.ready = (state_ff == S_RUN) && !stale_ff && !q_full;
   assign take      = req.valid && req.ready;
   assign is_emit   = req.opcode == nnis_pkg::OP_EMIT;
   assign cnt_wide  = sr * sc;
   assign count_in  = cnt_wide[AW:0];

   // source index lookup, clamped in case sizes changed mid-frame
   always_comb begin
      r_idx     = (rowq_ff >= NW'(sr)) ? (sr - SW'(1)) : rowq_ff[SW-1:0];
      c_idx     = (colq_ff >= NW'(sc)) ? (sc - SW'(1)) : colq_ff[SW-1:0];
      addr_wide = (2*SW)'(r_idx) * (2*SW)'(sc) + (2*SW)'(c_idx);
      la_cur    = ({1'b0, la_ff} >= count_ff) ? '0 : la_ff;
      la_nxt    = {1'b0, la_cur} + (AW+1)'(1);
      q_addr    = is_emit ? addr_wide[AW-1:0] : la_cur;
      col_p1    = CW'(col_ff) + CW'(1);
      row_p1    = CW'(row_ff) + CW'(1);
      col_last  = col_p1 >= CW'(dc);
      row_last  = row_p1 >= CW'(dr);
      rsum      = (DW+1)'(rowr_ff) + (DW+1)'(rsr_ff);
      csum      = (DW+1)'(colr_ff) + (DW+1)'(csr_r_ff);
      rcarry    = rsum >= (DW+1)'(dr);
      ccarry    = csum >= (DW+1)'(dc);
   end

   always_comb begin
      q_ctl.is_emit    = is_emit;
      q_ctl.frame_done = col_last && row_last;
      q_push           = take;
      q_entry          = {q_ctl, RCW'(row_ff), RCW'(col_ff), q_addr, req.pixel_in};
   end

   // register writes
   always_comb begin
      src_rows_in = src_rows_ff;
      src_cols_in = src_cols_ff;
      dst_rows_in = dst_rows_ff;
      dst_cols_in = dst_cols_ff;
      if (csr_wr) begin
         case (csr.index)
            nnis_pkg::REG_SRC_ROWS: src_rows_in = csr.data[nnis_pkg::CSR_SRC_W-1:0];
            nnis_pkg::REG_SRC_COLS: src_cols_in = csr.data[nnis_pkg::CSR_SRC_W-1:0];
            nnis_pkg::REG_DST_ROWS: dst_rows_in = csr.data[nnis_pkg::CSR_DST_W-1:0];
            nnis_pkg::REG_DST_COLS: dst_cols_in = csr.data[nnis_pkg::CSR_DST_W-1:0];
            default: ;
         endcase
      end
   end

   // divider operand select
   always_comb begin
      div_start = state_ff == S_START;
      case (sel_ff)
         SEL_ROW_STEP: begin
            div_dividend = NW'(sr);
            div_divisor  = dr;
         end
         SEL_COL_STEP: begin
            div_dividend = NW'(sc);
            div_divisor  = dc;
         end
         SEL_ROW_POS: begin
            div_dividend = NW'(row_ff) * NW'(sr);
            div_divisor  = dr;
         end
         SEL_COL_POS: begin
            div_dividend = NW'(col_ff) * NW'(sc);
            div_divisor  = dc;
         end
         default: begin
            div_dividend = NW'(sr);
            div_divisor  = dr;
         end
      endcase
   end

   // sequencer and counters
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      stale_in = stale_ff;
      la_in    = la_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      rowq_in  = rowq_ff;
      rowr_in  = rowr_ff;
      colq_in  = colq_ff;
      colr_in  = colr_ff;
      rsq_in   = rsq_ff;
      rsr_in   = rsr_ff;
      csq_in   = csq_ff;
      csr_r_in = csr_r_ff;

      case (state_ff)
         S_RUN: begin
            if (stale_ff) begin
               state_in = S_START;
               sel_in   = SEL_ROW_STEP;
               stale_in = 1'b0;
            end
         end
         S_START: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (div_done) begin
               case (sel_ff)
                  SEL_ROW_STEP: begin
                     rsq_in = div_quo[SW-1:0];
                     rsr_in = div_rem;
                  end
                  SEL_COL_STEP: begin
                     csq_in   = div_quo[SW-1:0];
                     csr_r_in = div_rem;
                  end
                  SEL_ROW_POS: begin
                     rowq_in = div_quo;
                     rowr_in = div_rem;
                  end
                  SEL_COL_POS: begin
                     colq_in = div_quo;
                     colr_in = div_rem;
                  end
                  default: ;
               endcase
               if (sel_ff == SEL_COL_POS) begin
                  state_in = S_RUN;
               end else begin
                  state_in = S_START;
                  sel_in   = sel_ff + 2'd1;
               end
            end
         end
         default: state_in = S_RUN;
      endcase

      if (csr_wr) begin
         stale_in = 1'b1;
      end

      if (take && !is_emit) begin
         la_in = (la_nxt >= count_ff) ? '0 : la_nxt[AW-1:0];
      end

      // step the destination position and the matching quotient/remainder pairs
      if (take && is_emit) begin
         if (col_last) begin
            col_in  = '0;
            colq_in = '0;
            colr_in = '0;
            if (row_last) begin
               row_in  = '0;
               rowq_in = '0;
               rowr_in = '0;
            end else begin
               row_in  = row_p1[RW-1:0];
               rowq_in = rowq_ff + NW'(rsq_ff) + NW'(rcarry);
               rowr_in = rcarry ? DW'(rsum - (DW+1)'(dr)) : DW'(rsum);
            end
         end else begin
            col_in  = col_p1[RW-1:0];
            colq_in = colq_ff + NW'(csq_ff) + NW'(ccarry);
            colr_in = ccarry ? DW'(csum - (DW+1)'(dc)) : DW'(csum);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_rows_ff <= nnis_pkg::RST_SRC_DIM;
         src_cols_ff <= nnis_pkg::RST_SRC_DIM;
         dst_rows_ff <= nnis_pkg::RST_DST_DIM;
         dst_cols_ff <= nnis_pkg::RST_DST_DIM;
         state_ff    <= S_RUN;
         sel_ff      <= SEL_ROW_STEP;
         stale_ff    <= 1'b1;
         la_ff       <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
      end else begin
         src_rows_ff <= src_rows_in;
         src_cols_ff <= src_cols_in;
         dst_rows_ff <= dst_rows_in;
         dst_cols_ff <= dst_cols_in;
         state_ff    <= state_in;
         sel_ff      <= sel_in;
         stale_ff    <= stale_in;
         la_ff       <= la_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
      end
   end

   // not reset; count follows the sizes and the recompute pass rebuilds the rest
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rowq_ff  <= rowq_in;
      rowr_ff  <= rowr_in;
      colq_ff  <= colq_in;
      colr_ff  <= colr_in;
      rsq_ff   <= rsq_in;
      rsr_ff   <= rsr_in;
      csq_ff   <= csq_in;
      csr_r_ff <= csr_r_in;
   end

endmodule

`default_nettype wire

>>> hw/rtl/nnis_back.sv
// ----------------------------------------------------------------------------
// nnis_back
// Frame store, read stage and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nnis_back #(
   parameter int MAX_SRC_DIM = nnis_pkg::MAX_SRC_DIM_DEF,
   parameter int PIXEL_BITS  = nnis_pkg::PIXEL_BITS_DEF,
   parameter int ENTRY_W     = nnis_pkg::entry_width(MAX_SRC_DIM, PIXEL_BITS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [ENTRY_W-1:0] q_head,
   input  logic               q_empty,
   output logic               q_pop,
   nnis_rsp_if.source         rsp
);

   localparam int AW    = nnis_pkg::addr_width(MAX_SRC_DIM);
   localparam int DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;
   localparam int RCW   = nnis_pkg::ROWCOL_W;

   logic [PIXEL_BITS-1:0] store_mem [DEPTH];

   nnis_pkg::nnis_ctl_type h_ctl;
   logic [RCW-1:0]        h_row, h_col;
   logic [AW-1:0]         h_addr;
   logic [PIXEL_BITS-1:0] h_pixel;

   logic                  rd_valid_ff, rd_valid_in;
   logic [PIXEL_BITS-1:0] rd_data_ff;
   logic [RCW-1:0]        rd_row_ff, rd_col_ff;
   logic                  rd_done_ff;

   logic                  out_valid_ff, out_valid_in;
   logic [PIXEL_BITS-1:0] out_pixel_ff;
   logic [RCW-1:0]        out_row_ff, out_col_ff;
   logic                  out_done_ff;

   logic advance;
   logic pop_load, pop_emit;

   assign {h_ctl, h_row, h_col, h_addr, h_pixel} = q_head;

   // loads retire at once; an emit needs the read stage free
   always_comb begin
      advance      = rd_valid_ff && (!out_valid_ff || rsp.ready);
      pop_load     = !q_empty && !h_ctl.is_emit;
      pop_emit     = !q_empty && h_ctl.is_emit && (!rd_valid_ff || advance);
      q_pop        = pop_load || pop_emit;
      rd_valid_in  = pop_emit ? 1'b1 : (advance ? 1'b0 : rd_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (pop_load) begin
         store_mem[h_addr] <= h_pixel;
      end
      if (pop_emit) begin
         rd_data_ff <= store_mem[h_addr];
         rd_row_ff  <= h_row;
         rd_col_ff  <= h_col;
         rd_done_ff <= h_ctl.frame_done;
      end
      if (advance) begin
         out_pixel_ff <= rd_data_ff;
         out_row_ff   <= rd_row_ff;
         out_col_ff   <= rd_col_ff;
         out_done_ff  <= rd_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.pixel_out  = out_pixel_ff;
   assign rsp.out_row    = out_row_ff;
   assign rsp.out_col    = out_col_ff;
   assign rsp.frame_done = out_done_ff;

endmodule

`default_nettype wire

>>> hw/rtl/nearest_neighbor_image_scaler.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler - nearest-neighbor RGB resizer, top level
// An emit's result passes the queue, the read stage and the output register.
// Throughput: 1 item per cycle (one frame store write or read per cycle) while
// no recompute, full queue or rsp back-pressure stalls. Reset: sizes 256,
// counters 0; then index recompute with req not ready, rerun after every csr transfer.
// ----------------------------------------------------------------------------
`default_nettype none

// Structure
//   front : takes req transfers, owns the size registers, the load address
//           and the destination row/col walk. Source row/col indexes come
//           from quotient/remainder accumulators stepped by a precomputed
//           step (size ratio) instead of a per-pixel divide. After reset or
//           any register write a shared serial divider rebuilds the steps
//           and the accumulators for the current position, dividing NW-bit
//           values, NW = log2(MAX_DST_DIM) + source size width.
//   queue : QUEUE_DEPTH-entry FIFO of classified items (load or emit with
//           its frame store address), so front and back stall on their own.
//   back  : the frame store (one write or one read per cycle, registered
//           read data), then an output register for the rsp channel.
// Loads and emits stay in order through the queue, so an emit always sees
// every load accepted before it.

module nearest_neighbor_image_scaler #(
   parameter int MAX_SRC_DIM = nnis_pkg::MAX_SRC_DIM_DEF,
   parameter int MAX_DST_DIM = nnis_pkg::MAX_DST_DIM_DEF,
   parameter int PIXEL_BITS  = nnis_pkg::PIXEL_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   nnis_req_if.sink    req_chan,
   nnis_rsp_if.source  rsp_chan,
   nnis_csr_if.sink    csr_chan
);

   localparam int ENTRY_W = nnis_pkg::entry_width(MAX_SRC_DIM, PIXEL_BITS);

   // front -> queue
   logic               q_push;
   logic [ENTRY_W-1:0] q_wdata;
   logic               q_full;

   // queue -> back
   logic               q_pop;
   logic [ENTRY_W-1:0] q_head;
   logic               q_empty;

   nnis_front #(
      .MAX_SRC_DIM (MAX_SRC_DIM),
      .MAX_DST_DIM (MAX_DST_DIM),
      .PIXEL_BITS  (PIXEL_BITS),
      .ENTRY_W     (ENTRY_W)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .csr     (csr_chan),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (q_wdata)
   );

   nnis_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (nnis_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_head),
      .empty (q_empty)
   );

   // back drains the queue: loads write the store, emits read it
   nnis_back #(
      .MAX_SRC_DIM (MAX_SRC_DIM),
      .PIXEL_BITS  (PIXEL_BITS),
      .ENTRY_W     (ENTRY_W)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_head  (q_head),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .rsp     (rsp_chan)
   );

endmodule

`default_nettype wire

>>> hw/rtl/nnis_checker.sv
// ----------------------------------------------------------------------------
// nnis_checker
// Port-level checks of the scaler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module nnis_checker #(
   parameter int PIXEL_BITS = nnis_pkg::PIXEL_BITS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [PIXEL_BITS-1:0]         rsp_pixel,
   input logic [nnis_pkg::ROWCOL_W-1:0] rsp_row,
   input logic [nnis_pkg::ROWCOL_W-1:0] rsp_col,
   input logic                          rsp_done,
   input logic                          csr_valid,
   input logic                          csr_ready
);

   logic rsp_stall;
   logic csr_xfer;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign csr_xfer  = csr_valid && csr_ready;

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_pixel) && $stable(rsp_row) && $stable(rsp_col) && $stable(rsp_done))
   // reset empties the output register
   `ASSERT_NEXT_ALWAYS(a_rst_rsp, clock, reset, !rsp_valid)
   // index rebuild follows reset
   `ASSERT_NEXT_ALWAYS(a_rst_req, clock, reset, !req_ready)
   // a register write stops intake while the indexes are rebuilt
   `ASSERT_NEXT(a_csr_req, clock, reset, csr_xfer, !req_ready)

endmodule

bind nearest_neighbor_image_scaler nnis_checker #(
   .PIXEL_BITS (PIXEL_BITS)
) u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_pixel (rsp_chan.pixel_out),
   .rsp_row   (rsp_chan.out_row),
   .rsp_col   (rsp_chan.out_col),
   .rsp_done  (rsp_chan.frame_done),
   .csr_valid (csr_chan.valid),
   .csr_ready (csr_chan.ready)
);

`default_nettype wire

>>> verif/nearest_neighbor_image_scaler_checker.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler_checker
// Watches the req, rsp and csr channels of the scaler, keeps its own copy of
// the frame store, the size registers and the load/emit counters, predicts
// every scaled pixel and compares each rsp transfer with the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module nearest_neighbor_image_scaler_checker (
   input  logic clock,
   input  logic reset,
   nnis_req_if  req_chan,
   nnis_rsp_if  rsp_chan,
   nnis_csr_if  csr_chan,
   output logic emit_safe,       // next emit would read a written store entry
   output int   pending,         // scaled pixels still owed by the block
   output int   fail_count,
   output int   pixels_checked,
   output int   frames_seen
);

   localparam int SRC_LIMIT   = nnis_pkg::MAX_SRC_DIM_DEF;
   localparam int DST_LIMIT   = nnis_pkg::MAX_DST_DIM_DEF;
   localparam int PIX_W       = nnis_pkg::PIXEL_BITS_DEF;
   localparam int RCW         = nnis_pkg::ROWCOL_W;
   localparam int SRC_W       = nnis_pkg::CSR_SRC_W;
   localparam int DST_W       = nnis_pkg::CSR_DST_W;
   localparam int STORE_WORDS = SRC_LIMIT * SRC_LIMIT;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [RCW-1:0]   row;
      logic [RCW-1:0]   col;
      logic             done;
   } scaled_pixel_type;

   logic [SRC_W-1:0]  src_rows_reg, src_cols_reg;
   logic [DST_W-1:0]  dst_rows_reg, dst_cols_reg;
   logic [PIX_W-1:0]  pixel_mem [STORE_WORDS];
   bit                written   [STORE_WORDS];
   int unsigned       load_ptr, row_ptr, col_ptr;
   int unsigned       sr, sc, dr, dc, rd_addr;
   scaled_pixel_type  scaled_q [$];
   scaled_pixel_type  want, got;

   // 0 acts as 1, oversize acts as the maximum
   function automatic int unsigned eff_dim(input int unsigned v, input int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
   endfunction

   function automatic int unsigned nearest_src(input int unsigned pos, input int unsigned src,
                                               input int unsigned dst);
      int unsigned idx;
      idx = (pos * src) / dst;
      if (idx >= src) idx = src - 1;   // sizes changed mid frame
      return idx;
   endfunction

   task automatic check_field(input string field, input longint unsigned exp_v,
                              input longint unsigned act_v);
      if (exp_v != act_v) begin
         fail_count++;
         $display("%0t ns: rsp %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, field, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         src_rows_reg   = nnis_pkg::RST_SRC_DIM;
         src_cols_reg   = nnis_pkg::RST_SRC_DIM;
         dst_rows_reg   = nnis_pkg::RST_DST_DIM;
         dst_cols_reg   = nnis_pkg::RST_DST_DIM;
         load_ptr       = 0;
         row_ptr        = 0;
         col_ptr        = 0;
         scaled_q.delete();
         fail_count     = 0;
         pixels_checked = 0;
         frames_seen    = 0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.index)
               nnis_pkg::REG_SRC_ROWS: src_rows_reg = csr_chan.data[SRC_W-1:0];
               nnis_pkg::REG_SRC_COLS: src_cols_reg = csr_chan.data[SRC_W-1:0];
               nnis_pkg::REG_DST_ROWS: dst_rows_reg = csr_chan.data[DST_W-1:0];
               nnis_pkg::REG_DST_COLS: dst_cols_reg = csr_chan.data[DST_W-1:0];
               default: ;
            endcase
         end

         sr = eff_dim(src_rows_reg, SRC_LIMIT);
         sc = eff_dim(src_cols_reg, SRC_LIMIT);
         dr = eff_dim(dst_rows_reg, DST_LIMIT);
         dc = eff_dim(dst_cols_reg, DST_LIMIT);

         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.opcode == nnis_pkg::OP_LOAD) begin
               if (load_ptr >= sr * sc) load_ptr = 0;
               pixel_mem[load_ptr] = req_chan.pixel_in;
               written[load_ptr]   = 1'b1;
               load_ptr++;
               if (load_ptr >= sr * sc) load_ptr = 0;
            end else begin
               rd_addr    = (nearest_src(row_ptr, sr, dr) * sc + nearest_src(col_ptr, sc, dc))
                            % STORE_WORDS;
               want.pixel = pixel_mem[rd_addr];
               want.row   = row_ptr[RCW-1:0];
               want.col   = col_ptr[RCW-1:0];
               want.done  = 1'b0;
               if (col_ptr + 1 >= dc) begin
                  col_ptr = 0;
                  if (row_ptr + 1 >= dr) begin
                     row_ptr   = 0;
                     want.done = 1'b1;
                  end else begin
                     row_ptr++;
                  end
               end else begin
                  col_ptr++;
               end
               scaled_q.push_back(want);
            end
         end

         if (rsp_chan.valid && rsp_chan.ready) begin
            if (scaled_q.size() == 0) begin
               fail_count++;
               $display("%0t ns: unexpected rsp, expected none, actual pixel 0x%0h",
                        $time, rsp_chan.pixel_out);
               $display("   row %0d col %0d done %0b",
                        rsp_chan.out_row, rsp_chan.out_col, rsp_chan.frame_done);
            end else begin
               got = scaled_q.pop_front();
               check_field("pixel_out", got.pixel, rsp_chan.pixel_out);
               check_field("out_row", got.row, rsp_chan.out_row);
               check_field("out_col", got.col, rsp_chan.out_col);
               check_field("frame_done", got.done, rsp_chan.frame_done);
               pixels_checked++;
            end
            if (rsp_chan.frame_done) frames_seen++;
         end
      end

      // legality of the next emit under the state after this edge
      sr        = eff_dim(src_rows_reg, SRC_LIMIT);
      sc        = eff_dim(src_cols_reg, SRC_LIMIT);
      dr        = eff_dim(dst_rows_reg, DST_LIMIT);
      dc        = eff_dim(dst_cols_reg, DST_LIMIT);
      rd_addr   = (nearest_src(row_ptr, sr, dr) * sc + nearest_src(col_ptr, sc, dc))
                  % STORE_WORDS;
      emit_safe = written[rd_addr];
      pending   = scaled_q.size();
   end

endmodule

>>> verif/nearest_neighbor_image_scaler_tb.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler_tb
// Drives pixel loads, emit requests and size register writes into the
// scaler, with bursty req traffic and a patterned rsp stall. A checker beside
// the block predicts and compares every scaled pixel; this top gives the
// verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module nearest_neighbor_image_scaler_tb;

   localparam int PIX_W  = nnis_pkg::PIXEL_BITS_DEF;
   localparam int IDX_W  = nnis_pkg::CSR_IDX_W;
   localparam int DATA_W = nnis_pkg::CSR_DATA_W;
   localparam int SRC_W  = nnis_pkg::CSR_SRC_W;
   localparam int DST_W  = nnis_pkg::CSR_DST_W;

   // Run budget. Slowest sane run: ~1300 items, each behind the longest req gap
   // and the longest rsp stall, plus ~25 size settings of up to 5 csr transfers
   // each retriggering the index recompute. The limit takes that several
   // times over.
   localparam int CYCLE_LIMIT  = 400000;
   localparam int TARGET_ITEMS = 1300;
   // Loads produce no rsp, so the last one may still sit in the decoupling
   // queue when the last pixel arrives: the wait covers the read stage and
   // output register plus the queue depth, with margin.
   localparam int DRAIN_CYCLES = 2 + nnis_pkg::QUEUE_DEPTH + 10;

   // rsp back-pressure patterns
   typedef enum int {
      SINK_FULL_RATE,
      SINK_RANDOM,
      SINK_PERIODIC,
      SINK_LONG_STALL
   } sink_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   nnis_req_if req_chan ();
   nnis_rsp_if rsp_chan ();
   nnis_csr_if csr_chan ();

   logic emit_safe;
   int   pending, fail_count, pixels_checked, frames_seen;

   int            burst_left = 0;
   int            n_loads    = 0;
   int            n_emits    = 0;
   int            n_settings = 0;
   int            cycle_count = 0;
   sink_mode_type sink_mode  = SINK_FULL_RATE;
   int            sink_left  = 0;
   int            sink_tick  = 0;

   always #1 clock = ~clock;

   nearest_neighbor_image_scaler i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   nearest_neighbor_image_scaler_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_chan       (csr_chan),
      .emit_safe      (emit_safe),
      .pending        (pending),
      .fail_count     (fail_count),
      .pixels_checked (pixels_checked),
      .frames_seen    (frames_seen)
   );

   // Watchdog: a hang anywhere (req never ready, rsp never offered) ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d pixels still owed", cycle_count, pending);
         $display("Verification failed");
         $finish;
      end
   end

   // rsp ready: the pattern switches at random intervals between full
   // rate, coin flips, a periodic duty cycle and long stalls, so the stall
   // lands on every phase of the block's pipeline and queue fill.
   always @(negedge clock) begin
      if (sink_left == 0) begin
         sink_mode = sink_mode_type'($urandom_range(SINK_FULL_RATE, SINK_LONG_STALL));
         sink_left = $urandom_range(50, 300);
      end
      sink_left--;
      sink_tick++;
      case (sink_mode)
         SINK_FULL_RATE:  rsp_chan.ready <= 1'b1;
         SINK_RANDOM:     rsp_chan.ready <= 1'($urandom_range(0, 1));
         SINK_PERIODIC:   rsp_chan.ready <= (sink_tick % 8) < 5;
         SINK_LONG_STALL: rsp_chan.ready <= (sink_tick % 24) >= 16;
         default:         rsp_chan.ready <= 1'b1;
      endcase
   end

   // One req transfer. Called at a falling edge, returns at the falling edge
   // after the transfer with valid still high, so back-to-back items within
   // a burst keep valid asserted. An emit that would read a store entry never
   // loaded is turned into a load, which walks the load pointer toward it.
   task automatic send_item(input logic want_emit, input logic [PIX_W-1:0] pix);
      logic op;
      if (burst_left == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      op = (want_emit && emit_safe) ? nnis_pkg::OP_EMIT : nnis_pkg::OP_LOAD;
      req_chan.valid    <= 1'b1;
      req_chan.opcode   <= op;
      req_chan.pixel_in <= pix;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      burst_left--;
      if (op == nnis_pkg::OP_EMIT) n_emits++;
      else n_loads++;
   endtask

   // Drop valid and let the block go quiet: every owed pixel delivered and
   // any trailing load flushed out of the queue.
   task automatic wait_drain();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Single csr transfer; valid spends a cycle low afterwards so two writes
   // never lower and raise it in the same step.
   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
      @(negedge clock);
   endtask

   // New image/scaled sizes, written only with the block idle. Half the
   // time the unused upper data bits carry junk; now and then a write to an
   // index past the last register goes in too, which must change nothing.
   task automatic set_sizes(input logic [SRC_W-1:0] s_rows, input logic [SRC_W-1:0] s_cols,
                            input logic [DST_W-1:0] d_rows, input logic [DST_W-1:0] d_cols);
      logic [DATA_W-1:0] junk;
      junk = ($urandom_range(0, 1) != 0) ? DATA_W'($urandom) : '0;
      wait_drain();
      write_reg(nnis_pkg::REG_SRC_ROWS, {junk[DATA_W-1:SRC_W], s_rows});
      write_reg(nnis_pkg::REG_SRC_COLS, {junk[DATA_W-1:SRC_W], s_cols});
      write_reg(nnis_pkg::REG_DST_ROWS, {junk[DATA_W-1:DST_W], d_rows});
      write_reg(nnis_pkg::REG_DST_COLS, {junk[DATA_W-1:DST_W], d_cols});
      if ($urandom_range(0, 3) == 0)
         write_reg(IDX_W'($urandom_range(32'(nnis_pkg::REG_DST_COLS) + 32'd1, 255)),
                   DATA_W'($urandom));
      n_settings++;
   endtask

   task automatic run_phase(input int n_items, input int emit_pct);
      repeat (n_items) send_item($urandom_range(1, 100) <= emit_pct, PIX_W'($urandom));
   endtask

   initial begin
      logic [SRC_W-1:0] s_rows, s_cols;
      logic [DST_W-1:0] d_rows, d_cols;

      req_chan.valid    = 1'b0;
      req_chan.opcode   = nnis_pkg::OP_LOAD;
      req_chan.pixel_in = '0;
      rsp_chan.ready    = 1'b0;
      csr_chan.valid    = 1'b0;
      csr_chan.index    = '0;
      csr_chan.data     = '0;

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed part ---------------------------------------------------
      // Reset sizes (256x256 -> 256x256): emit (0,j) reads source (0,j), so
      // six loads feed six emits. Pixel values hit all-zeros, all-ones and
      // alternating bit patterns.
      send_item(1'b0, 24'h000000);
      send_item(1'b0, 24'hFFFFFF);
      send_item(1'b0, 24'h800001);
      send_item(1'b0, 24'h7FFFFE);
      send_item(1'b0, 24'h555555);
      send_item(1'b0, 24'hAAAAAA);
      repeat (6) send_item(1'b1, '0);

      // 1x1 -> 1x1: every emit closes a frame, every load wraps the load
      // pointer; the column counter left at 6 reads source column 0 and wraps on the first emit.
      set_sizes(9'd1, 9'd1, 13'd1, 13'd1);
      send_item(1'b0, 24'hC3C3C3);
      repeat (3) send_item(1'b1, '0);

      // zero sizes act as 1; a write to the top register index is ignored
      set_sizes('0, '0, '0, '0);
      write_reg('1, '1);
      send_item(1'b0, 24'h3C3C3C);
      repeat (2) send_item(1'b1, '0);

      // --- extreme sizes ---------------------------------------------------
      // tall column: 256 source rows blown up to 4096 scaled rows
      set_sizes(9'd256, 9'd1, 13'd4096, 13'd1);
      run_phase(300, 50);
      // wide row: reuses the entries just loaded
      set_sizes(9'd1, 9'd256, 13'd1, 13'd4096);
      run_phase(150, 80);
      // oversize values clamp to 256x256 -> 4096x4096
      set_sizes(9'd511, 9'd300, 13'd8191, 13'd5000);
      run_phase(60, 60);
      // full source collapsed to one pixel, source indexes clamped mid frame
      set_sizes(9'd256, 9'd256, 13'd1, 13'd1);
      run_phase(30, 70);

      // --- random sizes ----------------------------------------------------
      // Small images so that loads cover the source and scaled frames
      // complete often; occasional zero or oversize registers on top.
      while (n_loads + n_emits < TARGET_ITEMS) begin
         s_rows = SRC_W'($urandom_range(1, 8));
         s_cols = SRC_W'($urandom_range(1, 8));
         d_rows = DST_W'($urandom_range(1, 6));
         d_cols = DST_W'($urandom_range(1, 8));
         case ($urandom_range(0, 7))
            0: s_rows = '0;
            1: d_cols = '0;
            2: begin
               s_rows = 9'd1;                       // keep reads inside loaded entries
               s_cols = SRC_W'($urandom_range(257, 511));
            end
            3: d_rows = DST_W'($urandom_range(4097, 8191));
            default: ;
         endcase
         set_sizes(s_rows, s_cols, d_rows, d_cols);
         run_phase($urandom_range(30, 80), 60);
      end

      wait_drain();

      $display("Run covered %0d pixel loads and %0d emits over %0d size settings,",
               n_loads, n_emits, n_settings);
      $display("with %0d scaled pixels compared and %0d scaled frames completed.",
               pixels_checked, frames_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
